/* design/sha_pkg.sv */
// ----------------------------------------------------------------------------
// sha_pkg
// Shared constants and round functions of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

	// item mode codes
	localparam logic [1:0] MODE_APPEND        = 2'd0;
	localparam logic [1:0] MODE_APPEND_FINISH = 2'd1;
	localparam logic [1:0] MODE_FINISH        = 2'd2;
	localparam logic [1:0] MODE_IGNORE        = 2'd3;

	// padding marker byte
	localparam logic [7:0] PAD_MARK = 8'h80;

	// byte position where the length field starts
	localparam logic [5:0] LEN_POS = 6'd56;

	// initial hash words
	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// round constants
	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	// compression sigma on a
	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	// compression sigma on e
	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	// schedule sigma on w[i-15]
	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	// schedule sigma on w[i-2]
	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
	endfunction

endpackage

/* design/sha_if.sv */
// ----------------------------------------------------------------------------
// sha_in_if / sha_out_if
// Valid/ready channels of the SHA-256 stream hasher: byte beats in,
// digest word beats out.
// ----------------------------------------------------------------------------
interface sha_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] byte_value;

	modport source (output valid, output mode, output byte_value, input ready);
	modport sink   (input valid, input mode, input byte_value, output ready);
endinterface

interface sha_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_word;
	logic [1:0]  word_index;
	logic        last_word;

	modport source (output valid, output digest_word, output word_index,
		output last_word, input ready);
	modport sink   (input valid, input digest_word, input word_index,
		input last_word, output ready);
endinterface

/* design/sha256_stream_hasher_unit.sv */
// ----------------------------------------------------------------------------
// sha256_stream_hasher_unit
// SHA-256 over a byte stream with padding and a four-beat digest output.
// ----------------------------------------------------------------------------
// Each 64th message byte starts the compression, which runs one round per
// cycle on a single round unit: 64 rounds, then the chaining add. A finish
// pads one byte per cycle (0x80, zeros, then the eight length bytes), pausing
// for a compression when a block fills, runs one or two compressions and then
// offers the digest as four 64-bit beats, most significant first; the unit
// takes no input while a compression runs, nor from a finish until the last
// digest beat is taken. The hash state then returns to its initial value.
// Mode three beats are taken and dropped.
module sha256_stream_hasher_unit (
	input  logic            clk,
	input  logic            arst_n,
	sha_in_if.sink          item,
	sha_out_if.source       result
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_PAD,
		ST_LEN,
		ST_OUT
	} state_t;

	state_t        state_q;
	state_t        ret_q;
	logic [5:0]    fill_q;
	logic [54:0]   blk_cnt_q;
	logic          pad_first_q;
	logic [5:0]    rnd_q;
	logic [1:0]    idx_q;
	logic [31:0]   chain_q [8];

	logic [511:0]  buf_q;
	logic [31:0]   work_q [8];
	logic [63:0]   len_q;

	logic          accept;
	logic          shift_en;
	logic [7:0]    shift_byte;
	logic          comp_start;
	logic          len_load;

	logic [31:0]   w0, w1, w9, w14, w_new;
	logic [31:0]   t1, t2, ch, maj;

	// handshake
	assign item.ready   = arst_n && (state_q == ST_IDLE);
	assign accept       = item.valid && item.ready;

	// digest beats straight from the chaining registers
	assign result.valid       = (state_q == ST_OUT);
	assign result.digest_word = {chain_q[{idx_q, 1'b0}], chain_q[{idx_q, 1'b1}]};
	assign result.word_index  = idx_q;
	assign result.last_word   = &idx_q;

	// byte shift control
	always_comb begin
		shift_en   = 1'b0;
		shift_byte = 8'h00;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && item.mode != sha_pkg::MODE_IGNORE
						&& item.mode != sha_pkg::MODE_FINISH) begin
					shift_en   = 1'b1;
					shift_byte = item.byte_value;
				end
			end
			ST_PAD: begin
				if (pad_first_q || fill_q != sha_pkg::LEN_POS) begin
					shift_en   = 1'b1;
					shift_byte = pad_first_q ? sha_pkg::PAD_MARK : 8'h00;
				end
			end
			ST_LEN: begin
				shift_en   = 1'b1;
				shift_byte = len_q[63:56];
			end
			default: begin
				shift_en   = 1'b0;
				shift_byte = 8'h00;
			end
		endcase
	end

	assign comp_start = shift_en && (&fill_q);
	assign len_load   = (state_q == ST_PAD) && pad_first_q;

	// message schedule window taps
	assign w0  = buf_q[511:480];
	assign w1  = buf_q[479:448];
	assign w9  = buf_q[223:192];
	assign w14 = buf_q[63:32];
	assign w_new = sha_pkg::small_sigma1(w14) + w9 + sha_pkg::small_sigma0(w1) + w0;

	// round function
	assign ch  = (work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]);
	assign maj = (work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2])
		^ (work_q[1] & work_q[2]);
	assign t1  = work_q[7] + sha_pkg::big_sigma1(work_q[4]) + ch
		+ sha_pkg::ROUND_K[rnd_q] + w0;
	assign t2  = sha_pkg::big_sigma0(work_q[0]) + maj;

	// sequencer and hash state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			fill_q      <= '0;
			blk_cnt_q   <= '0;
			pad_first_q <= 1'b0;
			rnd_q       <= '0;
			idx_q       <= '0;
			for (int i = 0; i < 8; i++) chain_q[i] <= sha_pkg::INIT_HASH[i];
		end else begin
			if (shift_en) fill_q <= fill_q + 6'd1;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && item.mode != sha_pkg::MODE_IGNORE) begin
						pad_first_q <= 1'b1;
						if (comp_start) begin
							state_q <= ST_ROUND;
							rnd_q   <= '0;
							ret_q   <= (item.mode == sha_pkg::MODE_APPEND) ? ST_IDLE : ST_PAD;
						end else if (item.mode != sha_pkg::MODE_APPEND) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					pad_first_q <= 1'b0;
					if (comp_start) begin
						state_q <= ST_ROUND;
						rnd_q   <= '0;
						ret_q   <= ST_PAD;
					end else if (!shift_en) begin
						state_q <= ST_LEN;
					end
				end
				ST_LEN: begin
					if (comp_start) begin
						state_q <= ST_ROUND;
						rnd_q   <= '0;
						ret_q   <= ST_OUT;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (&rnd_q) state_q <= ST_ADD;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] + work_q[i];
					blk_cnt_q <= blk_cnt_q + 55'd1;
					state_q   <= ret_q;
				end
				ST_OUT: begin
					if (result.ready) begin
						idx_q <= idx_q + 2'd1;
						if (&idx_q) begin
							state_q   <= ST_IDLE;
							fill_q    <= '0;
							blk_cnt_q <= '0;
							for (int i = 0; i < 8; i++) chain_q[i] <= sha_pkg::INIT_HASH[i];
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// block buffer, working variables and length field
	always_ff @(posedge clk) begin
		if (len_load) len_q <= {blk_cnt_q, fill_q, 3'b000};
		else if (state_q == ST_LEN) len_q <= {len_q[55:0], 8'h00};

		if (shift_en) buf_q <= {buf_q[503:0], shift_byte};
		else if (state_q == ST_ROUND) buf_q <= {buf_q[479:0], w_new};

		if (comp_start) begin
			for (int i = 0; i < 8; i++) work_q[i] <= chain_q[i];
		end else if (state_q == ST_ROUND) begin
			work_q[7] <= work_q[6];
			work_q[6] <= work_q[5];
			work_q[5] <= work_q[4];
			work_q[4] <= work_q[3] + t1;
			work_q[3] <= work_q[2];
			work_q[2] <= work_q[1];
			work_q[1] <= work_q[0];
			work_q[0] <= t1 + t2;
		end
	end

	// checks
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !item.ready)
		else $error("input taken while digest pending");

	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND && (&rnd_q)) |=> state_q == ST_ADD)
		else $error("compression did not end after the last round");

	a_clear_after_digest: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.ready && result.last_word)
		|=> (fill_q == 6'd0 && blk_cnt_q == 55'd0 && state_q == ST_IDLE))
		else $error("hash state not cleared after final digest beat");

endmodule

/* test/tb_sha256_stream_hasher_unit.sv */
// ----------------------------------------------------------------------------
// tb_sha256_stream_hasher_unit
// Self-checking bench for the SHA-256 stream hasher. A short table of byte
// beats comes first, with the empty message and "abc" digests typed in. It is
// followed by random messages of random length, with dropped mode-three beats
// mixed in. A local SHA-256 predictor follows every accepted byte beat and
// queues the four digest word beats of each finish, and every output beat is
// checked against the head of that queue. Both channels idle at random, and
// the output side holds off once for a long stretch so that the input backs
// up.
// ----------------------------------------------------------------------------
module tb_sha256_stream_hasher_unit;

	localparam int RUN_LIMIT   = 400000;
	localparam int SQUEEZE_LEN = 400;
	localparam int DRAIN_WAIT  = 400;
	localparam int ITEM_TARGET = 140;

	localparam logic [255:0] EMPTY_DIGEST =
		256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
	localparam logic [255:0] ABC_DIGEST =
		256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

	localparam logic [31:0] SHA_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] SHA_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef struct packed {
		logic [63:0] digest_word;
		logic [1:0]  word_index;
		logic        last_word;
	} digest_beat_t;

	typedef struct packed {
		logic [1:0]   mode;
		logic [7:0]   value;
		logic         typed;
		logic [255:0] digest;
	} script_row_t;

	logic clk = 1'b0;
	logic arst_n;

	sha_in_if  item_ch ();
	sha_out_if result_ch ();

	sha256_stream_hasher_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	always #2 clk = ~clk;

	// predictor state
	logic [31:0] chain [8];
	logic [7:0]  blk [64];
	int          fill;
	logic [63:0] bits_done;

	digest_beat_t pending_words [$];
	int  fault_count = 0;
	int  items_sent = 0;
	bit  calm = 1'b0;
	bit  squeeze = 1'b0;
	int  cycles = 0;

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// one 64-round compression of the block buffer into the chaining value
	function automatic void crunch_block();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1;
		logic [31:0] t2;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		for (int i = 16; i < 64; i++)
			w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7] +
				(ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
		v = chain;
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25)) +
				((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + w[i];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22)) +
				((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain[i] = chain[i] + v[i];
	endfunction

	function automatic void hash_restart();
		chain = SHA_IV;
		fill = 0;
		bits_done = '0;
	endfunction

	// follows one accepted beat; returns 1 with the digest when it finishes
	function automatic bit hash_item(input logic [1:0] m, input logic [7:0] b,
		output logic [255:0] d);
		logic [63:0] total;
		d = '0;
		if (m == sha_pkg::MODE_IGNORE)
			return 1'b0;
		if (m != sha_pkg::MODE_FINISH) begin
			blk[fill] = b;
			fill++;
			if (fill == 64) begin
				crunch_block();
				bits_done = bits_done + 64'd512;
				fill = 0;
			end
		end
		if (m == sha_pkg::MODE_APPEND)
			return 1'b0;
		// padding, spilling into a second block when the length does not fit
		total = bits_done + 64'(fill) * 64'd8;
		blk[fill] = 8'h80;
		for (int i = fill + 1; i < 64; i++)
			blk[i] = 8'h00;
		if (fill >= 56) begin
			crunch_block();
			for (int i = 0; i < 56; i++)
				blk[i] = 8'h00;
		end
		for (int i = 0; i < 8; i++)
			blk[56 + i] = total[63 - 8*i -: 8];
		crunch_block();
		d = {chain[0], chain[1], chain[2], chain[3], chain[4], chain[5], chain[6], chain[7]};
		hash_restart();
		return 1'b1;
	endfunction

	// offers one beat, with a random gap ahead of it, and predicts on acceptance
	task automatic offer(input logic [1:0] m, input logic [7:0] b, input logic typed,
		input logic [255:0] typed_digest);
		logic [255:0] d;
		digest_beat_t beat;
		if (!calm && $urandom_range(0, 4) == 0) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		item_ch.valid      <= 1'b1;
		item_ch.mode       <= m;
		item_ch.byte_value <= b;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		if (m != sha_pkg::MODE_IGNORE)
			items_sent++;
		if (hash_item(m, b, d)) begin
			if (typed)
				d = typed_digest;
			for (int k = 0; k < 4; k++) begin
				beat.digest_word = d[255 - 64*k -: 64];
				beat.word_index  = 2'(k);
				beat.last_word   = (k == 3);
				pending_words.push_back(beat);
			end
		end
	endtask

	// random message; closed by its last byte or by a separate finish beat
	task automatic send_message(input int len, input bit close_on_byte);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 11) == 0)
				offer(sha_pkg::MODE_IGNORE, 8'($urandom_range(0, 255)), 1'b0, '0);
			offer((close_on_byte && i == len - 1) ?
				sha_pkg::MODE_APPEND_FINISH : sha_pkg::MODE_APPEND,
				8'($urandom_range(0, 255)), 1'b0, '0);
		end
		if (!close_on_byte || len == 0)
			offer(sha_pkg::MODE_FINISH, 8'($urandom_range(0, 255)), 1'b0, '0);
	endtask

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == RUN_LIMIT) begin
			$display("tb_sha256_stream_hasher_unit: done, errors");
			$finish;
		end
	end

	// output side: random stalls, one long hold-off, and the beat checks
	initial begin
		int hold;
		bit squeezed;
		digest_beat_t want;
		hold = 0;
		squeezed = 1'b0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && result_ch.valid && result_ch.ready) begin
				if (pending_words.size() == 0) begin
					$error("unexpected digest beat: digest_word %h word_index %0d",
						result_ch.digest_word, result_ch.word_index);
					fault_count++;
				end else begin
					want = pending_words.pop_front();
					if (result_ch.digest_word !== want.digest_word) begin
						$error("digest_word: expected %h, got %h",
							want.digest_word, result_ch.digest_word);
						fault_count++;
					end
					if (result_ch.word_index !== want.word_index) begin
						$error("word_index: expected %0d, got %0d",
							want.word_index, result_ch.word_index);
						fault_count++;
					end
					if (result_ch.last_word !== want.last_word) begin
						$error("last_word: expected %0d, got %0d",
							want.last_word, result_ch.last_word);
						fault_count++;
					end
				end
			end
			if (squeeze && !squeezed) begin
				squeezed = 1'b1;
				hold = SQUEEZE_LEN;
			end else if (hold == 0 && !calm && $urandom_range(0, 9) == 0) begin
				hold = $urandom_range(1, 14);
			end
			if (hold > 0) begin
				hold--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// stimulus
	initial begin
		script_row_t script [12];
		script = '{
			'{sha_pkg::MODE_FINISH,        8'h5a, 1'b1, EMPTY_DIGEST},
			'{sha_pkg::MODE_APPEND,        8'h61, 1'b0, 256'h0},
			'{sha_pkg::MODE_IGNORE,        8'hff, 1'b0, 256'h0},
			'{sha_pkg::MODE_APPEND,        8'h62, 1'b0, 256'h0},
			'{sha_pkg::MODE_IGNORE,        8'h00, 1'b0, 256'h0},
			'{sha_pkg::MODE_APPEND_FINISH, 8'h63, 1'b1, ABC_DIGEST},
			'{sha_pkg::MODE_APPEND_FINISH, 8'h00, 1'b0, 256'h0},
			'{sha_pkg::MODE_APPEND_FINISH, 8'hff, 1'b0, 256'h0},
			'{sha_pkg::MODE_APPEND,        8'hff, 1'b0, 256'h0},
			'{sha_pkg::MODE_APPEND,        8'h00, 1'b0, 256'h0},
			'{sha_pkg::MODE_FINISH,        8'h00, 1'b0, 256'h0},
			'{sha_pkg::MODE_FINISH,        8'hff, 1'b1, EMPTY_DIGEST}
		};
		hash_restart();
		arst_n             <= 1'b0;
		item_ch.valid      <= 1'b0;
		item_ch.mode       <= sha_pkg::MODE_APPEND;
		item_ch.byte_value <= 8'h00;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows
		foreach (script[r])
			offer(script[r].mode, script[r].value, script[r].typed, script[r].digest);

		// padding spill at fill 56
		send_message(56, 1'b1);

		// long hold-off on the output while the next message keeps coming
		squeeze = 1'b1;

		// a finish right on a block boundary
		send_message(64, 1'b0);

		// short random messages, with no idling in this last stretch
		calm = 1'b1;
		while (items_sent < ITEM_TARGET)
			send_message($urandom_range(0, 12), $urandom_range(0, 1));
		item_ch.valid <= 1'b0;

		// drain, then watch for stray beats
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fault_count == 0)
			$display("tb_sha256_stream_hasher_unit: done, clean");
		else
			$display("tb_sha256_stream_hasher_unit: done, errors");
		$finish;
	end

endmodule

/* sha256_stream_hasher_unit.f */
design/sha_pkg.sv
design/sha_if.sv
design/sha256_stream_hasher_unit.sv
test/tb_sha256_stream_hasher_unit.sv
